[src/ldm_pkg.sv]
// ----------------------------------------------------------------------------
// ldm_pkg
// Shared types and fixed constants of the line diff marker.
// ----------------------------------------------------------------------------
package ldm_pkg;

    // Fixed widths of the line and mark transaction fields.
    localparam int KEY_PORT_W = 32;
    localparam int LINE_NUM_W = 7;

    // Flags produced by the shared compare unit.
    typedef struct packed {
        logic eq;
        logic up_gt_left;
    } ldm_cmp_t;

endpackage

[src/ldm_line_if.sv]
// ----------------------------------------------------------------------------
// ldm_line_if
// Valid/ready channel that carries one line key per transaction.
// ----------------------------------------------------------------------------
interface ldm_line_if;
    import ldm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  sequence_select;
    logic [KEY_PORT_W-1:0] line_key;
    logic                  last_line;

    modport source (
        output valid,
        output sequence_select,
        output line_key,
        output last_line,
        input  ready
    );

    modport sink (
        input  valid,
        input  sequence_select,
        input  line_key,
        input  last_line,
        output ready
    );

endinterface

[src/ldm_mark_if.sv]
// ----------------------------------------------------------------------------
// ldm_mark_if
// Valid/ready channel that carries one line report per transaction.
// ----------------------------------------------------------------------------
interface ldm_mark_if;
    import ldm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LINE_NUM_W-1:0] line_number;
    logic                  is_new;
    logic                  last_result;

    modport source (
        output valid,
        output line_number,
        output is_new,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  line_number,
        input  is_new,
        input  last_result,
        output ready
    );

endinterface

[src/ldm_cell_unit.sv]
// ----------------------------------------------------------------------------
// ldm_cell_unit
// Shared key compare and length select unit, used both to fill the length
// table and to choose each backtrack step.
// ----------------------------------------------------------------------------
module ldm_cell_unit #(
    parameter int KEY_W = 32,
    parameter int VAL_W = 7
) (
    input  logic [KEY_W-1:0] key_a,
    input  logic [KEY_W-1:0] key_b,
    input  logic [VAL_W-1:0] diag,
    input  logic [VAL_W-1:0] up,
    input  logic [VAL_W-1:0] left,
    output ldm_pkg::ldm_cmp_t cmp,
    output logic [VAL_W-1:0] value
);
    import ldm_pkg::*;

    // Key equality and the strict comparison of the two neighbouring cells.
    assign cmp.eq         = (key_a == key_b);
    assign cmp.up_gt_left = (up > left);

    // A match extends the diagonal length, otherwise the larger neighbour wins, left on a tie.
    always_comb
    begin
        if (cmp.eq)
        begin
            value = diag + VAL_W'(1);
        end
        else if (cmp.up_gt_left)
        begin
            value = up;
        end
        else
        begin
            value = left;
        end
    end

endmodule

[src/lcs_line_diff_marker_core.sv]
// ----------------------------------------------------------------------------
// lcs_line_diff_marker_core
// Longest-common-subsequence line diff that marks new lines of a text.
// ----------------------------------------------------------------------------
// Line keys are taken one per cycle, each tagged as original or current. The
// final current line starts the diff and the block takes no further line until
// every report has been delivered. With m original and n current lines the diff
// clears the match flags, fills the length table (each cell is a read then a
// write of the single table memory through the shared cell unit), walks back
// through the table (at most m+n-1 backtrack steps, each a table read then a
// decision) and delivers one report per current line in order. With no
// original lines stored the fill and the backtrack are skipped.
// ----------------------------------------------------------------------------
module lcs_line_diff_marker_core #(
    parameter int MAX_LINES = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ldm_line_if.sink  lines,
    ldm_mark_if.source marks
);
    import ldm_pkg::*;

    localparam int KEY_W     = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int CNT_W     = $clog2(MAX_LINES + 1);
    localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int TAB_DEPTH = MAX_LINES * MAX_LINES;
    localparam int TAB_W     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LINES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [TAB_W-1:0] ROW_STEP = TAB_W'(MAX_LINES);
    localparam logic [TAB_W-1:0] TAB_ONE  = TAB_W'(1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FWR  = 3'd3;
    localparam logic [2:0] S_BRD  = 3'd4;
    localparam logic [2:0] S_BDEC = 3'd5;
    localparam logic [2:0] S_ORD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // Control registers and their next values.
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] orig_cnt_reg, orig_cnt_next;
    logic [CNT_W-1:0] cur_cnt_reg, cur_cnt_next;
    logic             orig_restart_reg, orig_restart_next;
    logic             cur_restart_reg, cur_restart_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [TAB_W-1:0] row_base_reg, row_base_next;
    logic [CNT_W-1:0] diag_reg, diag_next;
    logic [CNT_W-1:0] left_reg, left_next;

    // Memories and their registered read data.
    logic [KEY_W-1:0] orig_mem [MAX_LINES];
    logic [KEY_W-1:0] cur_mem  [MAX_LINES];
    logic [CNT_W-1:0] tab_mem  [TAB_DEPTH];
    logic             flag_mem [MAX_LINES];
    logic [KEY_W-1:0] orig_rd_reg;
    logic [KEY_W-1:0] cur_rd_reg;
    logic [CNT_W-1:0] up_rd_reg;
    logic [CNT_W-1:0] left_rd_reg;
    logic             flag_rd_reg;

    // Memory access control.
    logic             orig_we;
    logic             cur_we;
    logic             tab_we;
    logic             flag_we;
    logic             flag_wr_data;
    logic [IDX_W-1:0] key_wr_idx;
    logic [IDX_W-1:0] flag_wr_idx;
    logic [IDX_W-1:0] orig_rd_idx;
    logic [IDX_W-1:0] cur_rd_idx;
    logic [IDX_W-1:0] k_idx;
    logic [TAB_W-1:0] tab_cur_addr;
    logic [TAB_W-1:0] up_addr;
    logic [TAB_W-1:0] left_addr;

    // Load and datapath helpers.
    logic             ld_restart;
    logic [CNT_W-1:0] ld_base;
    logic             ld_room;
    logic [CNT_W-1:0] ld_cnt;
    logic [CNT_W-1:0] i_dec;
    logic [CNT_W-1:0] j_dec;
    logic [CNT_W-1:0] k_inc;
    logic [CNT_W-1:0] up_val;
    logic [CNT_W-1:0] left_val;
    logic [CNT_W-1:0] cell_value;
    ldm_cmp_t         cell_cmp;
    logic             bt_done;

    // Position of the next stored line of the selected sequence.
    assign ld_restart = lines.sequence_select ? cur_restart_reg : orig_restart_reg;
    assign ld_base    = ld_restart ? '0
                      : (lines.sequence_select ? cur_cnt_reg : orig_cnt_reg);
    assign ld_room    = (ld_base < MAX_CNT);
    assign ld_cnt     = ld_room ? (ld_base + CNT_ONE) : ld_base;
    assign key_wr_idx = ld_base[IDX_W-1:0];

    // Index arithmetic for the table walk.
    assign i_dec        = i_reg - CNT_ONE;
    assign j_dec        = j_reg - CNT_ONE;
    assign k_inc        = k_reg + CNT_ONE;
    assign orig_rd_idx  = i_dec[IDX_W-1:0];
    assign cur_rd_idx   = j_dec[IDX_W-1:0];
    assign k_idx        = k_reg[IDX_W-1:0];
    assign tab_cur_addr = row_base_reg + TAB_W'(j_reg) - TAB_ONE;
    assign up_addr      = tab_cur_addr - ROW_STEP;
    assign left_addr    = tab_cur_addr - TAB_ONE;
    assign flag_wr_idx  = (state_reg == S_CLR) ? k_idx : cur_rd_idx;
    assign flag_wr_data = (state_reg != S_CLR);

    // Row zero and column zero of the table read as zero.
    assign up_val   = (i_reg == CNT_ONE) ? '0 : up_rd_reg;
    assign left_val = (state_reg == S_FWR) ? left_reg
                    : ((j_reg == CNT_ONE) ? '0 : left_rd_reg);

    // Shared compare and select unit.
    ldm_cell_unit #(
        .KEY_W (KEY_W),
        .VAL_W (CNT_W)
    ) u_cell (
        .key_a (orig_rd_reg),
        .key_b (cur_rd_reg),
        .diag  (diag_reg),
        .up    (up_val),
        .left  (left_val),
        .cmp   (cell_cmp),
        .value (cell_value)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        orig_cnt_next     = orig_cnt_reg;
        cur_cnt_next      = cur_cnt_reg;
        orig_restart_next = orig_restart_reg;
        cur_restart_next  = cur_restart_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        row_base_next     = row_base_reg;
        diag_next         = diag_reg;
        left_next         = left_reg;
        orig_we           = 1'b0;
        cur_we            = 1'b0;
        tab_we            = 1'b0;
        flag_we           = 1'b0;
        bt_done           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (lines.valid)
                begin
                    if (!lines.sequence_select)
                    begin
                        orig_we           = ld_room;
                        orig_cnt_next     = ld_cnt;
                        orig_restart_next = lines.last_line;
                    end
                    else
                    begin
                        cur_we           = ld_room;
                        cur_cnt_next     = ld_cnt;
                        cur_restart_next = lines.last_line;
                        if (lines.last_line)
                        begin
                            k_next     = '0;
                            state_next = S_CLR;
                        end
                    end
                end
            end

            S_CLR:
            begin
                flag_we = 1'b1;
                if (k_inc == cur_cnt_reg)
                begin
                    k_next = '0;
                    if (orig_cnt_reg == '0)
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        i_next        = CNT_ONE;
                        j_next        = CNT_ONE;
                        row_base_next = '0;
                        diag_next     = '0;
                        left_next     = '0;
                        state_next    = S_FRD;
                    end
                end
                else
                begin
                    k_next = k_inc;
                end
            end

            S_FRD:
            begin
                state_next = S_FWR;
            end

            S_FWR:
            begin
                tab_we    = 1'b1;
                diag_next = up_val;
                left_next = cell_value;
                if (j_reg == cur_cnt_reg)
                begin
                    if (i_reg == orig_cnt_reg)
                    begin
                        state_next = S_BRD;
                    end
                    else
                    begin
                        i_next        = i_reg + CNT_ONE;
                        j_next        = CNT_ONE;
                        row_base_next = row_base_reg + ROW_STEP;
                        diag_next     = '0;
                        left_next     = '0;
                        state_next    = S_FRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_ONE;
                    state_next = S_FRD;
                end
            end

            S_BRD:
            begin
                state_next = S_BDEC;
            end

            S_BDEC:
            begin
                priority if (cell_cmp.eq)
                begin
                    flag_we       = 1'b1;
                    i_next        = i_dec;
                    j_next        = j_dec;
                    row_base_next = row_base_reg - ROW_STEP;
                    bt_done       = (i_reg == CNT_ONE) || (j_reg == CNT_ONE);
                end
                else if (cell_cmp.up_gt_left)
                begin
                    i_next        = i_dec;
                    row_base_next = row_base_reg - ROW_STEP;
                    bt_done       = (i_reg == CNT_ONE);
                end
                else
                begin
                    j_next  = j_dec;
                    bt_done = (j_reg == CNT_ONE);
                end
                if (bt_done)
                begin
                    k_next     = '0;
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end

            S_ORD:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (marks.ready)
                begin
                    if (k_inc == cur_cnt_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = S_ORD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            orig_cnt_reg     <= '0;
            cur_cnt_reg      <= '0;
            orig_restart_reg <= 1'b1;
            cur_restart_reg  <= 1'b1;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            row_base_reg     <= '0;
            diag_reg         <= '0;
            left_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            orig_cnt_reg     <= orig_cnt_next;
            cur_cnt_reg      <= cur_cnt_next;
            orig_restart_reg <= orig_restart_next;
            cur_restart_reg  <= cur_restart_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            row_base_reg     <= row_base_next;
            diag_reg         <= diag_next;
            left_reg         <= left_next;
        end
    end

    // Original key memory.
    always_ff @(posedge clk)
    begin
        if (orig_we)
        begin
            orig_mem[key_wr_idx] <= lines.line_key[KEY_W-1:0];
        end
        orig_rd_reg <= orig_mem[orig_rd_idx];
    end

    // Current key memory.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[key_wr_idx] <= lines.line_key[KEY_W-1:0];
        end
        cur_rd_reg <= cur_mem[cur_rd_idx];
    end

    // Length table: one write port, upper and left read ports.
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_cur_addr] <= cell_value;
        end
        up_rd_reg   <= tab_mem[up_addr];
        left_rd_reg <= tab_mem[left_addr];
    end

    // Match flag memory.
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wr_idx] <= flag_wr_data;
        end
        flag_rd_reg <= flag_mem[k_idx];
    end

    // Handshake and report fields.
    assign lines.ready       = (state_reg == S_IDLE);
    assign marks.valid       = (state_reg == S_OUT);
    assign marks.line_number = LINE_NUM_W'(k_inc);
    assign marks.is_new      = ~flag_rd_reg;
    assign marks.last_result = (k_inc == cur_cnt_reg);

    // Loading and reporting never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(lines.ready && marks.valid))
        else $error("line channel ready while a report is pending");

    // The table fill stays inside the stored sequences.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWR) |-> (i_reg != '0 && j_reg != '0 &&
            i_reg <= orig_cnt_reg && j_reg <= cur_cnt_reg))
        else $error("table fill index outside the stored lines");

    // Backtrack steps only from a cell inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BRD) |-> (i_reg != '0 && j_reg != '0 &&
            i_reg <= orig_cnt_reg && j_reg <= cur_cnt_reg))
        else $error("backtrack from a cell outside the table");

    // Reports follow each other with consecutive line numbers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (marks.valid && marks.ready && !marks.last_result) |=> ##1
            (marks.valid &&
             marks.line_number == $past(marks.line_number, 2) + 7'd1))
        else $error("report line numbers not consecutive");

    // After the final report the block takes lines again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (marks.valid && marks.ready && marks.last_result) |=> lines.ready)
        else $error("block not idle after the final report");

endmodule
